### sv/pe_pool_allocator_top_macros.svh
// Assertion macros for the pool allocator top level.
`ifndef PE_POOL_ALLOCATOR_TOP_MACROS_SVH
`define PE_POOL_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PPA_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pool allocator assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PPA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pool allocator assertion failed");

`endif

### sv/ppa_pkg.sv
// Package: sizes, codes and shared types of the pool allocator.
`default_nettype none
package ppa_pkg;

    localparam int NUM_SLOTS = 128;
    localparam int NUM_KINDS = 16;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KIND_W = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
    localparam int KCNT_W = $clog2(NUM_KINDS + 1);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

    localparam int REQ_W    = 2;
    localparam int ID_W     = 32;
    localparam int SLOTF_W  = 7;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD,
        REQ_ACQUIRE,
        REQ_RELEASE,
        REQ_COUNT
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NONE_FREE,
        ST_UNKNOWN,
        ST_EMPTY_SLOT,
        ST_BAD_STATE,
        ST_KINDS_FULL
    } status_t;

    typedef struct packed {
        logic              hit;
        logic              full;
        logic [KIND_W-1:0] kind;
        logic [KIND_W-1:0] new_kind;
    } kind_lookup_t;

endpackage
`default_nettype wire

### sv/ppa_req_if.sv
// Interface: request channel of the pool allocator.
`default_nettype none
interface ppa_req_if;
    logic                        valid;
    logic                        ready;
    logic [ppa_pkg::REQ_W-1:0]   req_type;
    logic [ppa_pkg::ID_W-1:0]    kernel_id;
    logic [ppa_pkg::SLOTF_W-1:0] slot;

    modport source (output valid, output req_type, output kernel_id, output slot,
                    input ready);
    modport sink   (input valid, input req_type, input kernel_id, input slot,
                    output ready);
endinterface
`default_nettype wire

### sv/ppa_rsp_if.sv
// Interface: response channel of the pool allocator.
`default_nettype none
interface ppa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ppa_pkg::STATUS_W-1:0] status;
    logic [ppa_pkg::SLOTF_W-1:0]  granted_slot;
    logic [ppa_pkg::COUNT_W-1:0]  pe_count;
    logic [ppa_pkg::COUNT_W-1:0]  free_left;

    modport source (output valid, output status, output granted_slot, output pe_count,
                    output free_left, input ready);
    modport sink   (input valid, input status, input granted_slot, input pe_count,
                    input free_left, output ready);
endinterface
`default_nettype wire

### sv/ppa_kind_table.sv
// Kind table: kernel id keys, parallel match and allocation of new kinds.
`default_nettype none
module ppa_kind_table (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [ppa_pkg::ID_W-1:0] id,
    input  logic                     alloc,
    output ppa_pkg::kind_lookup_t    lookup
);
    import ppa_pkg::*;

    logic [ID_W-1:0]   kind_key_reg [NUM_KINDS];
    logic [KCNT_W-1:0] kinds_used_reg;
    logic [KCNT_W-1:0] kinds_used_next;
    logic [NUM_KINDS-1:0] hit_vec;
    logic [KIND_W-1:0]    hit_kind;

    always_comb
    begin
        hit_kind = '0;
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            hit_vec[k] = (KCNT_W'(k) < kinds_used_reg) && (kind_key_reg[k] == id)
                         && (id != '0);
            hit_kind   = hit_kind | (hit_vec[k] ? KIND_W'(k) : '0);
        end
    end

    always_comb
    begin
        lookup.hit      = |hit_vec;
        lookup.full     = (kinds_used_reg >= KCNT_W'(NUM_KINDS));
        lookup.kind     = hit_kind;
        lookup.new_kind = KIND_W'(kinds_used_reg);
        kinds_used_next = alloc ? kinds_used_reg + KCNT_W'(1) : kinds_used_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kinds_used_reg <= '0;
        end
        else
        begin
            kinds_used_reg <= kinds_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            kind_key_reg[KIND_W'(kinds_used_reg)] <= id;
        end
    end

endmodule
`default_nettype wire

### sv/pe_pool_allocator_top.sv
// Top level: processing-element slot pool with per-kernel free stacks.
//
// Usage:
//   req carries one transaction per request: load a slot with a kernel id,
//   acquire a free slot of a kernel, release a held slot, or count the slots
//   of a kernel. rsp returns exactly one transaction per request, in order,
//   with status, granted slot, slot count and free slots left in the kind.
//   A request accepted into the input register has its response registered
//   in the response register when rsp is not stalled. Throughput: one
//   request per cycle while rsp is not stalled; the whole request is handled
//   combinationally from the input register through the parallel kind match
//   into the per-kind stack registers. The slot kind and stack link memories
//   are read ahead: the kind at accept time, the next link after each pop.
//   Reset: all slots empty and not held, no kinds in use, all counts zero;
//   the block accepts requests right after reset, with no clearing pass.
//   Stall: while rsp.valid waits for rsp.ready, the response holds and one
//   more request is taken into the input register; then req.ready drops.
`default_nettype none
module pe_pool_allocator_top (
    input  logic clk,
    input  logic rst_n,
    ppa_req_if.sink   req,
    ppa_rsp_if.source rsp
);
    import ppa_pkg::*;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    req_type_t           s1_req_reg;
    logic [ID_W-1:0]     s1_id_reg;
    logic [SLOTF_W-1:0]  s1_slot_reg;

    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    status_t             rsp_status_reg;
    logic [SLOTF_W-1:0]  rsp_granted_reg;
    logic [COUNT_W-1:0]  rsp_count_reg;
    logic [COUNT_W-1:0]  rsp_left_reg;

    logic [NUM_SLOTS-1:0] slot_loaded_reg;
    logic [NUM_SLOTS-1:0] slot_held_reg;
    logic [KIND_W-1:0]    slot_kind_mem [NUM_SLOTS];
    logic [KIND_W-1:0]    kind_rd_reg;
    logic [SLOT_W-1:0]    link_mem [NUM_SLOTS];
    logic [SLOT_W-1:0]    link_rd_reg;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [KIND_W-1:0]    pend_kind_reg;

    logic [SLOT_W-1:0] stack_top_reg  [NUM_KINDS];
    logic [SLOT_W-1:0] stack_next_reg [NUM_KINDS];
    logic [CNT_W-1:0]  free_cnt_reg   [NUM_KINDS];
    logic [CNT_W-1:0]  total_cnt_reg  [NUM_KINDS];

    logic              accept;
    logic              advance;
    logic [SLOT_W-1:0] s1_idx;
    logic              in_range;
    kind_lookup_t      lookup;
    logic [KIND_W-1:0] k_sel;
    logic [SLOT_W-1:0] eff_top;
    logic [SLOT_W-1:0] eff_next;
    logic [CNT_W-1:0]  fc;
    logic [CNT_W-1:0]  tc;

    status_t            status;
    logic [SLOTF_W-1:0] granted;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] left;
    logic               do_load;
    logic               do_alloc;
    logic               do_push;
    logic               do_pop;

    ppa_kind_table u_kind_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .id     (s1_id_reg),
        .alloc  (advance && do_alloc),
        .lookup (lookup)
    );

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.granted_slot = rsp_granted_reg;
    assign rsp.pe_count     = rsp_count_reg;
    assign rsp.free_left    = rsp_left_reg;

    assign s1_idx   = SLOT_W'(s1_slot_reg);
    assign in_range = (32'(s1_slot_reg) < 32'(NUM_SLOTS));

    always_comb
    begin
        case (s1_req_reg)
            REQ_LOAD:    k_sel = lookup.hit ? lookup.kind : lookup.new_kind;
            REQ_RELEASE: k_sel = kind_rd_reg;
            default:     k_sel = lookup.kind;
        endcase
        eff_top  = stack_top_reg[k_sel];
        eff_next = (pend_valid_reg && (pend_kind_reg == k_sel)) ? link_rd_reg
                                                                : stack_next_reg[k_sel];
        fc = free_cnt_reg[k_sel];
        tc = total_cnt_reg[k_sel];
    end

    always_comb
    begin
        status   = ST_OK;
        granted  = '0;
        count    = '0;
        left     = '0;
        do_load  = 1'b0;
        do_alloc = 1'b0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        case (s1_req_reg)
            REQ_LOAD:
            begin
                if (!in_range || (s1_id_reg == '0))
                    status = ST_EMPTY_SLOT;
                else if (slot_loaded_reg[s1_idx])
                    status = ST_BAD_STATE;
                else if (!lookup.hit && lookup.full)
                    status = ST_KINDS_FULL;
                else
                begin
                    do_load  = 1'b1;
                    do_alloc = !lookup.hit;
                    do_push  = 1'b1;
                    left     = COUNT_W'(fc + CNT_W'(1));
                end
            end
            REQ_ACQUIRE:
            begin
                if (!lookup.hit)
                    status = ST_UNKNOWN;
                else if (fc == '0)
                    status = ST_NONE_FREE;
                else
                begin
                    do_pop  = 1'b1;
                    granted = SLOTF_W'(eff_top);
                    left    = COUNT_W'(fc - CNT_W'(1));
                end
            end
            REQ_RELEASE:
            begin
                if (!in_range || !slot_loaded_reg[s1_idx])
                    status = ST_EMPTY_SLOT;
                else if (!slot_held_reg[s1_idx])
                    status = ST_BAD_STATE;
                else
                begin
                    do_push = 1'b1;
                    left    = COUNT_W'(fc + CNT_W'(1));
                end
            end
            REQ_COUNT:
            begin
                if (lookup.hit)
                begin
                    count = COUNT_W'(tc);
                    left  = COUNT_W'(fc);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next   = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        rsp_valid_next  = advance ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
        pend_valid_next = advance && do_pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            slot_loaded_reg <= '0;
            slot_held_reg   <= '0;
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                free_cnt_reg[k]  <= '0;
                total_cnt_reg[k] <= '0;
            end
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (advance && do_load)
            begin
                slot_loaded_reg[s1_idx] <= 1'b1;
                total_cnt_reg[k_sel]    <= tc + CNT_W'(1);
            end
            if (advance && do_push)
            begin
                slot_held_reg[s1_idx] <= 1'b0;
                free_cnt_reg[k_sel]   <= fc + CNT_W'(1);
            end
            if (advance && do_pop)
            begin
                slot_held_reg[eff_top] <= 1'b1;
                free_cnt_reg[k_sel]    <= fc - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg  <= req_type_t'(req.req_type);
            s1_id_reg   <= req.kernel_id;
            s1_slot_reg <= req.slot;
            kind_rd_reg <= slot_kind_mem[SLOT_W'(req.slot)];
        end
        if (advance && do_load)
        begin
            slot_kind_mem[s1_idx] <= k_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            if (advance && do_push && (k_sel == KIND_W'(k)))
            begin
                stack_next_reg[k] <= eff_top;
            end
            else if (pend_valid_reg && (pend_kind_reg == KIND_W'(k)))
            begin
                stack_next_reg[k] <= link_rd_reg;
            end
        end
        if (advance && do_push)
        begin
            link_mem[s1_idx]     <= eff_top;
            stack_top_reg[k_sel] <= s1_idx;
        end
        if (advance && do_pop)
        begin
            stack_top_reg[k_sel] <= eff_next;
            link_rd_reg          <= link_mem[eff_next];
            pend_kind_reg        <= k_sel;
        end
        if (advance)
        begin
            rsp_status_reg  <= status;
            rsp_granted_reg <= granted;
            rsp_count_reg   <= count;
            rsp_left_reg    <= left;
        end
    end

`include "pe_pool_allocator_top_macros.svh"

    `PPA_ASSERT_IMPLIES(a_err_clears_fields, rsp_valid_reg && (rsp_status_reg != ST_OK),
        (rsp_left_reg == '0) && (rsp_granted_reg == '0))
    `PPA_ASSERT_NEXT(a_load_marks_slot, advance && do_load,
        slot_loaded_reg[$past(s1_idx)])
    `PPA_ASSERT_NEXT(a_pop_marks_held, advance && do_pop,
        slot_held_reg[$past(eff_top)])
    `PPA_ASSERT_IMPLIES(a_stall_blocks_input, rsp_valid_reg && !rsp.ready && s1_valid_reg,
        !req.ready)

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for pe_pool_allocator_top: table-driven and random requests checked in order.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import ppa_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RANDOM_ITEMS = 1230;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 250;
    localparam int PAUSE_AT     = 600;

    typedef struct packed {
        status_t              status;
        logic [SLOTF_W-1:0]   granted;
        logic [COUNT_W-1:0]   count;
        logic [COUNT_W-1:0]   left;
    } pool_rsp_t;

    typedef struct {
        req_type_t            rq;
        logic [ID_W-1:0]      id;
        logic [SLOTF_W-1:0]   s;
        bit                   typed;
        pool_rsp_t            rsp;
    } table_row_t;

    logic clk;
    logic rst_n;

    ppa_req_if req_ch ();
    ppa_rsp_if rsp_ch ();

    pe_pool_allocator_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [ID_W-1:0]   slot_owner_id [NUM_SLOTS] = '{default: '0};
    int                slot_kind_no  [NUM_SLOTS] = '{default: 0};
    bit                slot_busy     [NUM_SLOTS] = '{default: 1'b0};
    logic [SLOTF_W-1:0] slot_next    [NUM_SLOTS] = '{default: '0};
    logic [ID_W-1:0]   kind_id_tab   [NUM_KINDS] = '{default: '0};
    logic [SLOTF_W-1:0] kind_top     [NUM_KINDS] = '{default: '0};
    int                kind_free     [NUM_KINDS] = '{default: 0};
    int                kind_total    [NUM_KINDS] = '{default: 0};
    int                kinds_taken = 0;

    pool_rsp_t  expected_rsp_q [$];
    table_row_t directed_rows [$];
    logic [ID_W-1:0] known_ids [NUM_KINDS];
    int error_count = 0;
    int sent_count  = 0;
    int cycle_count = 0;

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    function automatic void push_free_slot(int k, logic [SLOTF_W-1:0] s);
        slot_next[s] = kind_top[k];
        kind_top[k]  = s;
        kind_free[k]++;
    endfunction

    function automatic pool_rsp_t pool_predict(req_type_t rq, logic [ID_W-1:0] id,
                                               logic [SLOTF_W-1:0] s);
        pool_rsp_t r;
        bit hit;
        int k;
        int i;
        logic [SLOTF_W-1:0] t;
        r = '{ST_OK, '0, '0, '0};
        hit = 1'b0;
        k = 0;
        if (id != '0)
        begin
            for (i = 0; i < kinds_taken; i++)
            begin
                if (!hit && kind_id_tab[i] == id)
                begin
                    hit = 1'b1;
                    k = i;
                end
            end
        end
        case (rq)
            REQ_LOAD:
            begin
                if (int'(s) >= NUM_SLOTS || id == '0)
                    r.status = ST_EMPTY_SLOT;
                else if (slot_owner_id[s] != '0)
                    r.status = ST_BAD_STATE;
                else
                begin
                    if (!hit)
                    begin
                        if (kinds_taken >= NUM_KINDS)
                            r.status = ST_KINDS_FULL;
                        else
                        begin
                            k = kinds_taken;
                            kind_id_tab[k] = id;
                            kinds_taken++;
                        end
                    end
                    if (r.status == ST_OK)
                    begin
                        slot_owner_id[s] = id;
                        slot_kind_no[s]  = k;
                        slot_busy[s]     = 1'b0;
                        kind_total[k]++;
                        push_free_slot(k, s);
                        r.left = COUNT_W'(kind_free[k]);
                    end
                end
            end
            REQ_ACQUIRE:
            begin
                if (!hit)
                    r.status = ST_UNKNOWN;
                else if (kind_free[k] == 0)
                    r.status = ST_NONE_FREE;
                else
                begin
                    t = kind_top[k];
                    kind_top[k] = slot_next[t];
                    kind_free[k]--;
                    slot_busy[t] = 1'b1;
                    r.granted = t;
                    r.left = COUNT_W'(kind_free[k]);
                end
            end
            REQ_RELEASE:
            begin
                if (int'(s) >= NUM_SLOTS || slot_owner_id[s] == '0)
                    r.status = ST_EMPTY_SLOT;
                else if (!slot_busy[s])
                    r.status = ST_BAD_STATE;
                else
                begin
                    k = slot_kind_no[s];
                    slot_busy[s] = 1'b0;
                    push_free_slot(k, s);
                    r.left = COUNT_W'(kind_free[k]);
                end
            end
            default:
            begin
                if (hit)
                begin
                    r.count = COUNT_W'(kind_total[k]);
                    r.left  = COUNT_W'(kind_free[k]);
                end
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(req_type_t rq, logic [ID_W-1:0] id,
                                    logic [SLOTF_W-1:0] s, bit typed, pool_rsp_t rsp);
        table_row_t row;
        row.rq = rq;
        row.id = id;
        row.s = s;
        row.typed = typed;
        row.rsp = rsp;
        directed_rows.push_back(row);
    endfunction

    task automatic issue_request(req_type_t rq, logic [ID_W-1:0] id, logic [SLOTF_W-1:0] s,
                                 bit typed, pool_rsp_t typed_rsp);
        int gap;
        pool_rsp_t predicted;
        gap = ((sent_count / 40) % 4 == 1) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rq;
        req_ch.kernel_id <= id;
        req_ch.slot      <= s;
        do @(posedge clk); while (!req_ch.ready);
        predicted = pool_predict(rq, id, s);
        expected_rsp_q.push_back(typed ? typed_rsp : predicted);
        sent_count++;
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_rsp_q.size() != 0);
    endtask

    initial
    begin
        int stall;
        int taken;
        pool_rsp_t exp_rsp;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = ((taken / 40) % 4 == 2) ? 0 : $urandom_range(0, 9);
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            taken++;
            if (expected_rsp_q.size() == 0)
            begin
                $error("response with no request outstanding: status %0d", rsp_ch.status);
                error_count++;
            end
            else
            begin
                exp_rsp = expected_rsp_q.pop_front();
                if (rsp_ch.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.granted_slot !== exp_rsp.granted)
                begin
                    $error("granted_slot: expected %0d, got %0d", exp_rsp.granted,
                           rsp_ch.granted_slot);
                    error_count++;
                end
                if (rsp_ch.pe_count !== exp_rsp.count)
                begin
                    $error("pe_count: expected %0d, got %0d", exp_rsp.count, rsp_ch.pe_count);
                    error_count++;
                end
                if (rsp_ch.free_left !== exp_rsp.left)
                begin
                    $error("free_left: expected %0d, got %0d", exp_rsp.left, rsp_ch.free_left);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        pool_rsp_t  no_rsp;
        table_row_t row;
        req_type_t  rq;
        logic [ID_W-1:0]    id;
        logic [SLOTF_W-1:0] s;
        int roll;
        int pick;
        int i;
        int empty_q [$];
        int held_q [$];

        no_rsp = '{ST_OK, '0, '0, '0};
        known_ids[0] = 32'hFFFF_FFFF;
        for (i = 1; i < NUM_KINDS; i++)
            known_ids[i] = (32'h0101_0101 * i) ^ (32'(i) << 27);

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_LOAD;
        req_ch.kernel_id <= '0;
        req_ch.slot      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(REQ_COUNT,   32'h0,        7'd0,   1'b1, '{ST_OK, 7'd0, 8'd0, 8'd0});
        add_row(REQ_ACQUIRE, 32'h0,        7'd0,   1'b1, '{ST_UNKNOWN, 7'd0, 8'd0, 8'd0});
        add_row(REQ_LOAD,    32'h0,        7'd5,   1'b1, '{ST_EMPTY_SLOT, 7'd0, 8'd0, 8'd0});
        add_row(REQ_RELEASE, 32'h0,        7'd0,   1'b1, '{ST_EMPTY_SLOT, 7'd0, 8'd0, 8'd0});
        add_row(REQ_LOAD,    known_ids[0], 7'd127, 1'b1, '{ST_OK, 7'd0, 8'd0, 8'd1});
        add_row(REQ_LOAD,    known_ids[1], 7'd127, 1'b1, '{ST_BAD_STATE, 7'd0, 8'd0, 8'd0});
        add_row(REQ_RELEASE, 32'h0,        7'd127, 1'b1, '{ST_BAD_STATE, 7'd0, 8'd0, 8'd0});
        add_row(REQ_COUNT,   known_ids[0], 7'd0,   1'b1, '{ST_OK, 7'd0, 8'd1, 8'd1});
        add_row(REQ_ACQUIRE, known_ids[0], 7'd0,   1'b1, '{ST_OK, 7'd127, 8'd0, 8'd0});
        add_row(REQ_ACQUIRE, known_ids[0], 7'd0,   1'b1, '{ST_NONE_FREE, 7'd0, 8'd0, 8'd0});
        add_row(REQ_RELEASE, 32'h0,        7'd127, 1'b1, '{ST_OK, 7'd0, 8'd0, 8'd1});
        for (i = 1; i < NUM_KINDS; i++)
            add_row(REQ_LOAD, known_ids[i], 7'(i), 1'b0, no_rsp);
        add_row(REQ_LOAD,    32'h8000_0000, 7'd16, 1'b1, '{ST_KINDS_FULL, 7'd0, 8'd0, 8'd0});

        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            issue_request(row.rq, row.id, row.s, row.typed, row.rsp);
        end
        drain_responses();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            empty_q.delete();
            held_q.delete();
            foreach (slot_owner_id[n])
            begin
                if (slot_owner_id[n] == '0)
                    empty_q.push_back(n);
                else if (slot_busy[n])
                    held_q.push_back(n);
            end
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            id = known_ids[$urandom_range(0, NUM_KINDS - 1)];
            s = 7'($urandom_range(0, NUM_SLOTS - 1));
            if (roll < 30)
            begin
                rq = REQ_LOAD;
                if (pick >= 95)
                    id = '0;
                else if (pick >= 80)
                    id = $urandom;
                if (empty_q.size() != 0 && $urandom_range(0, 99) < 70)
                    s = 7'(empty_q[$urandom_range(0, empty_q.size() - 1)]);
            end
            else if (roll < 60)
            begin
                rq = REQ_ACQUIRE;
                if (pick >= 96)
                    id = '0;
                else if (pick >= 88)
                    id = $urandom;
            end
            else if (roll < 85)
            begin
                rq = REQ_RELEASE;
                id = $urandom;
                if (held_q.size() != 0 && pick < 80)
                    s = 7'(held_q[$urandom_range(0, held_q.size() - 1)]);
            end
            else
            begin
                rq = REQ_COUNT;
                if (pick >= 92)
                    id = '0;
                else if (pick >= 80)
                    id = $urandom;
            end
            issue_request(rq, id, s, 1'b0, no_rsp);
            if (i == PAUSE_AT)
                drain_responses();
        end
        drain_responses();
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
